/* rtl/jtsq_pkg.sv */
package jtsq_pkg;

   localparam int CNT_W = 7;
   localparam int PAD_W = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] RESET_CLOCKS = CNT_W'(5);
   localparam logic [CNT_W-1:0] MAX_IDLE = CNT_W'(64);

   // csr register indexes
   localparam logic [1:0] CSR_IR_PAD_BEFORE = 2'd0;
   localparam logic [1:0] CSR_IR_PAD_AFTER  = 2'd1;
   localparam logic [1:0] CSR_DR_PAD_BEFORE = 2'd2;
   localparam logic [1:0] CSR_DR_PAD_AFTER  = 2'd3;

   typedef enum logic [1:0] {
      CMD_GOTO  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_IDLE  = 2'd2,
      CMD_SHIFT = 2'd3
   } cmd_kind_type;

   typedef enum logic [3:0] {
      ST_TLR   = 4'd0,
      ST_RTI   = 4'd1,
      ST_SELDR = 4'd2,
      ST_CAPDR = 4'd3,
      ST_SHDR  = 4'd4,
      ST_EX1DR = 4'd5,
      ST_PAUDR = 4'd6,
      ST_EX2DR = 4'd7,
      ST_UPDDR = 4'd8,
      ST_SELIR = 4'd9,
      ST_CAPIR = 4'd10,
      ST_SHIR  = 4'd11,
      ST_EX1IR = 4'd12,
      ST_PAUIR = 4'd13,
      ST_EX2IR = 4'd14,
      ST_UPDIR = 4'd15
   } tap_state_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_GOTO,
      SQ_RESET,
      SQ_CLOCKS,
      SQ_LEAD,
      SQ_DATA,
      SQ_TRAIL
   } seq_state_type;

   typedef struct packed {
      cmd_kind_type     kind;
      tap_state_type    target;
      logic [CNT_W-1:0] count;   // already saturated
      logic             tdi;
      logic             first;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic [PAD_W-1:0] ir_before;
      logic [PAD_W-1:0] ir_after;
      logic [PAD_W-1:0] dr_before;
      logic [PAD_W-1:0] dr_after;
   } pad_cfg_type;

   typedef struct packed {
      logic tms;
      logic tdi;
      logic sample;
      logic last;
   } slice_type;

   typedef struct packed {
      logic          tms;
      tap_state_type next;
   } route_type;

   // one move of the fixed routing table toward tgt
   function automatic route_type tap_route(input tap_state_type cur, input tap_state_type tgt);
      route_type r;
      r.tms  = 1'b1;
      r.next = cur;
      case (cur)
         ST_TLR: begin
            r.tms = 1'b0; r.next = ST_RTI;
         end
         ST_RTI: begin
            r.tms = 1'b1; r.next = ST_SELDR;
         end
         ST_SELDR: begin
            if (tgt >= ST_SELDR && tgt <= ST_UPDDR) begin
               r.tms = 1'b0; r.next = ST_CAPDR;
            end else begin
               r.tms = 1'b1; r.next = ST_SELIR;
            end
         end
         ST_CAPDR: begin
            if (tgt == ST_SHDR) begin
               r.tms = 1'b0; r.next = ST_SHDR;
            end else begin
               r.tms = 1'b1; r.next = ST_EX1DR;
            end
         end
         ST_SHDR: begin
            r.tms = 1'b1; r.next = ST_EX1DR;
         end
         ST_EX1DR: begin
            if (tgt == ST_PAUDR || tgt == ST_EX2DR) begin
               r.tms = 1'b0; r.next = ST_PAUDR;
            end else begin
               r.tms = 1'b1; r.next = ST_UPDDR;
            end
         end
         ST_PAUDR: begin
            r.tms = 1'b1; r.next = ST_EX2DR;
         end
         ST_EX2DR: begin
            if (tgt == ST_SHDR || tgt == ST_EX1DR || tgt == ST_PAUDR) begin
               r.tms = 1'b0; r.next = ST_SHDR;
            end else begin
               r.tms = 1'b1; r.next = ST_UPDDR;
            end
         end
         ST_SELIR: begin
            if (tgt != ST_TLR) begin
               r.tms = 1'b0; r.next = ST_CAPIR;
            end else begin
               r.tms = 1'b1; r.next = ST_TLR;
            end
         end
         ST_CAPIR: begin
            if (tgt == ST_SHIR) begin
               r.tms = 1'b0; r.next = ST_SHIR;
            end else begin
               r.tms = 1'b1; r.next = ST_EX1IR;
            end
         end
         ST_SHIR: begin
            r.tms = 1'b1; r.next = ST_EX1IR;
         end
         ST_EX1IR: begin
            if (tgt == ST_PAUIR || tgt == ST_EX2IR) begin
               r.tms = 1'b0; r.next = ST_PAUIR;
            end else begin
               r.tms = 1'b1; r.next = ST_UPDIR;
            end
         end
         ST_PAUIR: begin
            r.tms = 1'b1; r.next = ST_EX2IR;
         end
         ST_EX2IR: begin
            if (tgt == ST_SHIR || tgt == ST_EX1IR || tgt == ST_PAUIR) begin
               r.tms = 1'b0; r.next = ST_SHIR;
            end else begin
               r.tms = 1'b1; r.next = ST_UPDIR;
            end
         end
         default: begin
            // update-DR / update-IR
            if (tgt == ST_RTI) begin
               r.tms = 1'b0; r.next = ST_RTI;
            end else begin
               r.tms = 1'b1; r.next = ST_SELDR;
            end
         end
      endcase
      return r;
   endfunction

endpackage

/* rtl/jtsq_chan_if.sv */
interface jtsq_req_if import jtsq_pkg::*;;
   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [3:0]       target_state;
   logic [CNT_W-1:0] clock_count;
   logic             tdi_bit;
   logic             first_bit;
   logic             last_bit;

   modport source(output valid, func, target_state, clock_count, tdi_bit, first_bit,
                  last_bit, input ready);
   modport sink(input valid, func, target_state, clock_count, tdi_bit, first_bit,
                last_bit, output ready);
endinterface

interface jtsq_rsp_if;
   logic valid;
   logic ready;
   logic tms_out;
   logic tdi_out;
   logic sample_tdo;
   logic last_slice;

   modport source(output valid, tms_out, tdi_out, sample_tdo, last_slice, input ready);
   modport sink(input valid, tms_out, tdi_out, sample_tdo, last_slice, output ready);
endinterface

/* rtl/jtsq_front.sv */
module jtsq_front import jtsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   jtsq_req_if.sink     req_chan,
   output cmd_head_type q_head,
   input  logic         q_pop
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   cmd_type             dec;
   logic                push;

   // classify the request
   always_comb begin
      case (cmd_kind_type'(req_chan.func))
         CMD_GOTO:  dec.kind = CMD_GOTO;
         CMD_RESET: dec.kind = CMD_RESET;
         CMD_IDLE:  dec.kind = CMD_IDLE;
         default:   dec.kind = CMD_SHIFT;
      endcase
      dec.target = tap_state_type'(req_chan.target_state);
      dec.count  = (req_chan.clock_count > MAX_IDLE) ? MAX_IDLE : req_chan.clock_count;
      dec.tdi    = req_chan.tdi_bit;
      dec.first  = req_chan.first_bit;
      dec.last   = req_chan.last_bit;
   end

   assign req_chan.ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   assign q_head.valid = (fill_ff != '0);
   assign q_head.cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QFILL_W'(push) - QFILL_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* rtl/jtsq_back.sv */
module jtsq_back import jtsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_head_type q_head,
   output logic         q_pop,
   input  pad_cfg_type  pad_cfg,
   jtsq_rsp_if.source   rsp_chan
);

   seq_state_type    state_ff, state_in;
   tap_state_type    tap_ff, tap_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type          cmd_ff, cmd_in;
   logic             is_ir_ff, is_ir_in;
   logic [PAD_W-1:0] before_ff, before_in;
   logic             rsp_valid_ff;
   slice_type        slice_ff, slice;
   logic             emit, out_free, cnt_one;
   logic             head_is_ir;
   logic [PAD_W-1:0] head_before, head_after;
   route_type        step;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign cnt_one     = (cnt_ff == CNT_W'(1));
   assign head_is_ir  = (tap_ff == ST_SHIR);
   assign head_before = head_is_ir ? pad_cfg.ir_before : pad_cfg.dr_before;
   assign head_after  = head_is_ir ? pad_cfg.ir_after  : pad_cfg.dr_after;
   assign step        = tap_route(tap_ff, cmd_ff.target);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (q_head.valid) begin
               case (q_head.cmd.kind)
                  CMD_GOTO: begin
                     if (tap_ff != q_head.cmd.target) state_in = SQ_GOTO;
                  end
                  CMD_RESET: state_in = SQ_RESET;
                  CMD_IDLE: begin
                     if (q_head.cmd.count != '0) state_in = SQ_CLOCKS;
                  end
                  default: begin
                     state_in = (q_head.cmd.first && head_after != '0) ? SQ_LEAD : SQ_DATA;
                  end
               endcase
            end
         end
         SQ_GOTO: begin
            if (out_free && step.next == cmd_ff.target) state_in = SQ_IDLE;
         end
         SQ_RESET, SQ_CLOCKS, SQ_TRAIL: begin
            if (out_free && cnt_one) state_in = SQ_IDLE;
         end
         SQ_LEAD: begin
            if (out_free && cnt_one) state_in = SQ_DATA;
         end
         SQ_DATA: begin
            if (out_free) begin
               state_in = (cmd_ff.last && before_ff != '0) ? SQ_TRAIL : SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop     = 1'b0;
      emit      = 1'b0;
      slice     = '0;
      tap_in    = tap_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      is_ir_in  = is_ir_ff;
      before_in = before_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (q_head.valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_head.cmd;
               is_ir_in  = head_is_ir;
               before_in = head_before;
               case (q_head.cmd.kind)
                  CMD_RESET: cnt_in = RESET_CLOCKS;
                  CMD_IDLE:  cnt_in = q_head.cmd.count;
                  CMD_SHIFT: cnt_in = CNT_W'(head_after);
                  default:   cnt_in = cnt_ff;
               endcase
            end
         end
         SQ_GOTO: begin
            emit       = out_free;
            slice.tms  = step.tms;
            slice.last = (step.next == cmd_ff.target);
            if (out_free) tap_in = step.next;
         end
         SQ_RESET: begin
            emit       = out_free;
            slice.tms  = 1'b1;
            slice.last = cnt_one;
            if (out_free) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_one) tap_in = ST_TLR;
            end
         end
         SQ_CLOCKS: begin
            emit       = out_free;
            slice.last = cnt_one;
            if (out_free) cnt_in = cnt_ff - CNT_W'(1);
         end
         SQ_LEAD: begin
            emit      = out_free;
            slice.tdi = 1'b1;
            if (out_free) cnt_in = cnt_ff - CNT_W'(1);
         end
         SQ_DATA: begin
            emit         = out_free;
            slice.tms    = cmd_ff.last && (before_ff == '0);
            slice.tdi    = cmd_ff.tdi;
            slice.sample = 1'b1;
            slice.last   = !(cmd_ff.last && before_ff != '0);
            if (out_free) begin
               cnt_in = CNT_W'(before_ff);
               if (cmd_ff.last) tap_in = is_ir_ff ? ST_EX1IR : ST_EX1DR;
            end
         end
         SQ_TRAIL: begin
            emit       = out_free;
            slice.tms  = cnt_one;
            slice.tdi  = 1'b1;
            slice.last = cnt_one;
            if (out_free) cnt_in = cnt_ff - CNT_W'(1);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         tap_ff       <= ST_TLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      cmd_ff    <= cmd_in;
      is_ir_ff  <= is_ir_in;
      before_ff <= before_in;
      if (emit) slice_ff <= slice;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tms_out    = slice_ff.tms;
   assign rsp_chan.tdi_out    = slice_ff.tdi;
   assign rsp_chan.sample_tdo = slice_ff.sample;
   assign rsp_chan.last_slice = slice_ff.last;

endmodule

/* rtl/jtag_tap_master_sequencer_top.sv */
// Channel  | Dir | Handshake    | Payload
// req_chan | in  | valid/ready  | func, target_state, clock_count, tdi_bit, first_bit, last_bit
// rsp_chan | out | valid/ready  | tms_out, tdi_out, sample_tdo, last_slice
// csr_*    | in  | csr_we only  | csr_index selects pad register, csr_wdata[4:0]
//
// One TCK slice per clock once a command runs, while rsp_chan does not stall. The back-end
// sequencer pops each request from the queue and drives the slices through its single
// output register.
// Reset (synchronous, high) empties the 2-entry command queue and puts the TAP in TLR.
// A stalled rsp_chan holds the current slice; requests keep queuing until the queue fills.
module jtag_tap_master_sequencer_top import jtsq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   jtsq_req_if.sink         req_chan,
   jtsq_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [PAD_W-1:0] csr_wdata
);

   pad_cfg_type  pad_ff, pad_in;
   cmd_head_type q_head;
   logic         q_pop;

   // pad register bank
   always_comb begin
      pad_in = pad_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IR_PAD_BEFORE: pad_in.ir_before = csr_wdata;
            CSR_IR_PAD_AFTER:  pad_in.ir_after  = csr_wdata;
            CSR_DR_PAD_BEFORE: pad_in.dr_before = csr_wdata;
            CSR_DR_PAD_AFTER:  pad_in.dr_after  = csr_wdata;
            default:           pad_in = pad_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= '0;
      end else begin
         pad_ff <= pad_in;
      end
   end

   // front: decode + command queue
   jtsq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // back: TAP tracker and slice sequencer
   jtsq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .pad_cfg  (pad_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/jtsq_checker.sv */
module jtsq_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic tms_out,
   input logic tdi_out,
   input logic sample_tdo,
   input logic last_slice
);

   // a held slice must not drop or change
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({tms_out, tdi_out, sample_tdo, last_slice}))
      else $error("rsp slice dropped or changed while stalled");

   // queue accepting and output clear after reset
   ap_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not clean after reset");

   // a data bit that raises TMS is the exit slice and must be marked last
   ap_data_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_tdo && tms_out |-> last_slice)
      else $error("data exit slice not marked last");

   // trailing padding raises TMS only on its final slice
   ap_pad_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sample_tdo && tdi_out && tms_out |-> last_slice)
      else $error("padding exit slice not marked last");

endmodule

bind jtag_tap_master_sequencer_top jtsq_checker u_jtsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .tms_out    (rsp_chan.tms_out),
   .tdi_out    (rsp_chan.tdi_out),
   .sample_tdo (rsp_chan.sample_tdo),
   .last_slice (rsp_chan.last_slice)
);

/* verif/testbench.sv */
`default_nettype none

module testbench import jtsq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int RANDOM_REQUESTS = 180;
   localparam int CALM_REQUESTS   = 30;   // final stretch with no stalls on either side
   localparam int SETTLE_CYCLES   = 16;   // covers requests that make no slices
   localparam int CYCLE_LIMIT     = 1000000;

   // Expected-slice tracker: keeps its own TAP state and pad registers and
   // expands each accepted request into the TCK slices it must produce.
   class slice_scoreboard;
      tap_state_type tap;
      pad_cfg_type   pads;
      slice_type     expected[$];
      int            errors;
      int            slices_seen;

      function new();
         tap         = ST_TLR;
         pads        = '0;
         errors      = 0;
         slices_seen = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function void set_pad(logic [1:0] idx, logic [PAD_W-1:0] value);
         case (idx)
            CSR_IR_PAD_BEFORE: pads.ir_before = value;
            CSR_IR_PAD_AFTER:  pads.ir_after  = value;
            CSR_DR_PAD_BEFORE: pads.dr_before = value;
            default:           pads.dr_after  = value;
         endcase
      endfunction

      function void push_slice(logic tms, logic tdi, logic smp);
         slice_type s;
         s.tms    = tms;
         s.tdi    = tdi;
         s.sample = smp;
         s.last   = 1'b0;
         expected.push_back(s);
      endfunction

      // one routing step toward tgt; advances tap, returns the TMS level
      function logic hop(tap_state_type tgt);
         logic          tms_low;
         tap_state_type nxt;
         case (tap)
            ST_TLR: begin
               tms_low = 1'b1; nxt = ST_RTI;
            end
            ST_RTI: begin
               tms_low = 1'b0; nxt = ST_SELDR;
            end
            ST_SELDR: begin
               tms_low = (tgt >= ST_SELDR) && (tgt <= ST_UPDDR);
               nxt     = tms_low ? ST_CAPDR : ST_SELIR;
            end
            ST_CAPDR: begin
               tms_low = (tgt == ST_SHDR);
               nxt     = tms_low ? ST_SHDR : ST_EX1DR;
            end
            ST_SHDR: begin
               tms_low = 1'b0; nxt = ST_EX1DR;
            end
            ST_EX1DR: begin
               tms_low = tgt inside {ST_PAUDR, ST_EX2DR};
               nxt     = tms_low ? ST_PAUDR : ST_UPDDR;
            end
            ST_PAUDR: begin
               tms_low = 1'b0; nxt = ST_EX2DR;
            end
            ST_EX2DR: begin
               tms_low = tgt inside {ST_SHDR, ST_EX1DR, ST_PAUDR};
               nxt     = tms_low ? ST_SHDR : ST_UPDDR;
            end
            ST_SELIR: begin
               tms_low = (tgt != ST_TLR);
               nxt     = tms_low ? ST_CAPIR : ST_TLR;
            end
            ST_CAPIR: begin
               tms_low = (tgt == ST_SHIR);
               nxt     = tms_low ? ST_SHIR : ST_EX1IR;
            end
            ST_SHIR: begin
               tms_low = 1'b0; nxt = ST_EX1IR;
            end
            ST_EX1IR: begin
               tms_low = tgt inside {ST_PAUIR, ST_EX2IR};
               nxt     = tms_low ? ST_PAUIR : ST_UPDIR;
            end
            ST_PAUIR: begin
               tms_low = 1'b0; nxt = ST_EX2IR;
            end
            ST_EX2IR: begin
               tms_low = tgt inside {ST_SHIR, ST_EX1IR, ST_PAUIR};
               nxt     = tms_low ? ST_SHIR : ST_UPDIR;
            end
            default: begin
               // both update states
               tms_low = (tgt == ST_RTI);
               nxt     = tms_low ? ST_RTI : ST_SELDR;
            end
         endcase
         tap = nxt;
         return !tms_low;
      endfunction

      function void note_request(cmd_kind_type kind, tap_state_type tgt,
                                 logic [CNT_W-1:0] cnt, logic tdi, logic first, logic last);
         int        start;
         int        clocks;
         int        lead;
         int        trail;
         logic      in_ir;
         slice_type s;
         start = expected.size();
         case (kind)
            CMD_GOTO: begin
               for (int i = 0; i < 64 && tap != tgt; i++)
                  push_slice(hop(tgt), 1'b0, 1'b0);
            end
            CMD_RESET: begin
               repeat (RESET_CLOCKS) push_slice(1'b1, 1'b0, 1'b0);
               tap = ST_TLR;
            end
            CMD_IDLE: begin
               clocks = (cnt > MAX_IDLE) ? int'(MAX_IDLE) : int'(cnt);
               repeat (clocks) push_slice(1'b0, 1'b0, 1'b0);
            end
            default: begin
               // anything but Shift-IR counts as a DR shift
               in_ir = (tap == ST_SHIR);
               lead  = in_ir ? pads.ir_after : pads.dr_after;
               trail = in_ir ? pads.ir_before : pads.dr_before;
               if (first)
                  repeat (lead) push_slice(1'b0, 1'b1, 1'b0);
               push_slice(last && trail == 0, tdi, 1'b1);
               if (last) begin
                  for (int i = 0; i < trail; i++)
                     push_slice(i == trail - 1, 1'b1, 1'b0);
                  tap = in_ir ? ST_EX1IR : ST_EX1DR;
               end
            end
         endcase
         if (expected.size() > start) begin
            s      = expected.pop_back();
            s.last = 1'b1;
            expected.push_back(s);
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_slice(slice_type got);
         slice_type want;
         slices_seen++;
         if (expected.size() == 0) begin
            report($sformatf("slice %0d (tms/tdi/smp/last %b) with nothing pending",
                             slices_seen, got));
         end else begin
            want = expected.pop_front();
            if (got !== want)
               report($sformatf("slice %0d tms/tdi/smp/last got %b want %b",
                                slices_seen, got, want));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [PAD_W-1:0] csr_wdata;

   jtsq_req_if req_if();
   jtsq_rsp_if rsp_if();

   slice_scoreboard sb;
   int  requests_sent;
   int  cycles;
   logic calm;   // no stalls on either side once set

   jtag_tap_master_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // slice monitor: sample on the rising edge, before this edge's updates land
   always @(posedge clock) begin : slice_monitor
      slice_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.tms    = rsp_if.tms_out;
         got.tdi    = rsp_if.tdi_out;
         got.sample = rsp_if.sample_tdo;
         got.last   = rsp_if.last_slice;
         sb.check_slice(got);
      end
   end

   // slice consumer: random open/stall bursts, always open in the calm stretch
   initial begin : slice_consumer
      int   span;
      logic take;
      forever begin
         take = calm || ($urandom_range(0, 2) != 0);
         span = take ? $urandom_range(1, 30) : $urandom_range(1, 12);
         repeat (span) begin
            @(negedge clock);
            rsp_if.ready = take || calm;
         end
      end
   end

   // Drive one request, hold it until accepted, then maybe leave a gap.
   // valid stays high when the next request follows straight on.
   task automatic send_cmd(input cmd_kind_type kind, input logic [3:0] tgt,
                           input logic [CNT_W-1:0] cnt, input logic tdi,
                           input logic first, input logic last);
      int gap;
      @(negedge clock);
      req_if.valid        = 1'b1;
      req_if.func         = kind;
      req_if.target_state = tgt;
      req_if.clock_count  = cnt;
      req_if.tdi_bit      = tdi;
      req_if.first_bit    = first;
      req_if.last_bit     = last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(kind, tap_state_type'(tgt), cnt, tdi, first, last);
      requests_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // goto request; the unused fields carry random junk
   task automatic goto_state(input tap_state_type tgt);
      send_cmd(CMD_GOTO, tgt, CNT_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // hold off new requests until every expected slice is back, plus settle time
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all four pad registers, only while the block is idle
   task automatic write_pads(input logic [PAD_W-1:0] ir_before, input logic [PAD_W-1:0] ir_after,
                             input logic [PAD_W-1:0] dr_before, input logic [PAD_W-1:0] dr_after);
      logic [1:0]       idx [4];
      logic [PAD_W-1:0] val [4];
      idx = '{CSR_IR_PAD_BEFORE, CSR_IR_PAD_AFTER, CSR_DR_PAD_BEFORE, CSR_DR_PAD_AFTER};
      val = '{ir_before, ir_after, dr_before, dr_after};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = idx[i];
         csr_wdata = val[i];
         sb.set_pad(idx[i], val[i]);
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin : stimulus
      int   base;
      int   pick;
      int   nbits;
      logic broken;
      logic first;
      logic last;

      sb                  = new();
      requests_sent       = 0;
      calm                = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_IR_PAD_BEFORE;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.func         = CMD_GOTO;
      req_if.target_state = ST_TLR;
      req_if.clock_count  = '0;
      req_if.tdi_bit      = 1'b0;
      req_if.first_bit    = 1'b0;
      req_if.last_bit     = 1'b0;
      rsp_if.ready        = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed: no padding ----
      write_pads('0, '0, '0, '0);
      goto_state(ST_TLR);                                        // already there: no slices
      send_cmd(CMD_RESET, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b1, 1'b1);
      send_cmd(CMD_IDLE, 4'($urandom), '0, 1'b1, 1'b1, 1'b1);    // zero clocks: no slices
      send_cmd(CMD_IDLE, 4'($urandom), '1, 1'b0, 1'b0, 1'b0);    // saturates at 64
      send_cmd(CMD_IDLE, 4'($urandom), MAX_IDLE, 1'b1, 1'b0, 1'b1);
      goto_state(ST_SELDR);
      goto_state(ST_RTI);                                        // from Select-DR via Select-IR
      goto_state(ST_SHDR);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b1, 1'b1);

      // ---- directed: small uneven padding ----
      write_pads(PAD_W'(3), PAD_W'(2), PAD_W'(1), PAD_W'(4));
      goto_state(ST_SHIR);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b0, 1'b1, 1'b0);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b0, 1'b0);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b0, 1'b1);
      goto_state(ST_EX2IR);
      goto_state(ST_UPDDR);
      // shift while parked in Update-DR: DR pads, ends in Exit1-DR
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b1, 1'b1);
      goto_state(ST_TLR);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b0, 1'b1, 1'b0);

      // ---- directed: full padding ----
      write_pads('1, '1, '1, '1);
      goto_state(ST_SHIR);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b1, 1'b1, 1'b1);
      goto_state(ST_SHDR);
      send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'b0, 1'b1, 1'b1);
      goto_state(ST_PAUDR);
      goto_state(ST_TLR);

      // ---- random phases, each under its own pad setting ----
      base = requests_sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_pads(PAD_W'($urandom), PAD_W'($urandom), PAD_W'($urandom),
                          PAD_W'($urandom));
            1: write_pads('0, '0, '0, '0);
            2: write_pads(PAD_W'($urandom_range(0, 3)), PAD_W'($urandom_range(0, 3)),
                          PAD_W'($urandom_range(0, 3)), PAD_W'($urandom_range(0, 3)));
            default: write_pads('1, PAD_W'($urandom), '0, '1);
         endcase
         while (requests_sent < base + (ph + 1) * RANDOM_REQUESTS / 4) begin
            calm = (requests_sent >= base + RANDOM_REQUESTS - CALM_REQUESTS);
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               // well-formed shift: walk to a shift state, then a run of bits,
               // now and then with its first or last marker dropped
               goto_state($urandom_range(0, 1) ? ST_SHIR : ST_SHDR);
               nbits  = $urandom_range(1, 6);
               broken = ($urandom_range(0, 4) == 0);
               for (int k = 0; k < nbits; k++) begin
                  first = (k == 0) && !(broken && $urandom_range(0, 1));
                  last  = (k == nbits - 1) && !(broken && $urandom_range(0, 1));
                  send_cmd(CMD_SHIFT, 4'($urandom), CNT_W'($urandom), 1'($urandom),
                           first, last);
               end
               if ($urandom_range(0, 1))
                  goto_state(tap_state_type'($urandom_range(0, 15)));
            end else if (pick == 6) begin
               send_cmd(CMD_IDLE, 4'($urandom),
                        ($urandom_range(0, 7) == 0) ? CNT_W'($urandom)
                                                    : CNT_W'($urandom_range(0, 6)),
                        1'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick == 7) begin
               send_cmd(CMD_RESET, 4'($urandom), CNT_W'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom));
            end else begin
               // noise: any command with any field values
               send_cmd(cmd_kind_type'($urandom_range(0, 3)), 4'($urandom), CNT_W'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
            end
         end
      end

      // drain everything, then give the verdict
      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/jtsq_pkg.sv
rtl/jtsq_chan_if.sv
rtl/jtsq_front.sv
rtl/jtsq_back.sv
rtl/jtag_tap_master_sequencer_top.sv
rtl/jtsq_checker.sv
verif/testbench.sv
